@@ sv/etfp_pkg.sv @@
// ----------------------------------------------------------------------------
// etfp_pkg
// shared types and constants for the escape-time fractal pixel block
// ----------------------------------------------------------------------------
`default_nettype none
package etfp_pkg;
    localparam int FracBits   = 20;
    localparam int CoordW     = 31;   // holds values up to about +-1024 in Q.20
    localparam int ImageWidth = 1024;
    localparam int ImageHeight = 1024;
    localparam int MaxIter    = 100;
    localparam int CountW     = 7;

    localparam logic [1:0] RegMode = 2'd0;
    localparam logic [1:0] RegReal = 2'd1;
    localparam logic [1:0] RegImag = 2'd2;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    // token handed from cell to cell along the chain
    typedef struct packed {
        logic  live;
        logic  done;
        t_coord zr;
        t_coord zi;
        logic [CountW-1:0] count;
    } t_tok;
endpackage
`default_nettype wire

@@ sv/etfp_cell.sv @@
// ----------------------------------------------------------------------------
// etfp_cell
// one step z = z*z + c with escape check, registered token out
// ----------------------------------------------------------------------------
`default_nettype none
module etfp_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  etfp_pkg::t_tok      i_tok,
    input  etfp_pkg::t_coord    i_cr,
    input  etfp_pkg::t_coord    i_ci,
    output etfp_pkg::t_tok      o_tok
);
    localparam int PW = 2 * etfp_pkg::CoordW;
    localparam logic signed [etfp_pkg::CoordW-1:0] Lim =
        etfp_pkg::t_coord'(16) <<< etfp_pkg::FracBits;

    logic signed [PW-1:0] w_rr, w_ii, w_ri;
    logic signed [PW:0]   w_re, w_im;
    etfp_pkg::t_coord     w_nr, w_ni;
    logic                 w_esc;
    etfp_pkg::t_tok       r_tok, n_tok;

    // products; arithmetic shift gives floor
    always_comb begin
        w_rr = i_tok.zr * i_tok.zr;
        w_ii = i_tok.zi * i_tok.zi;
        w_ri = i_tok.zr * i_tok.zi;
        w_re = {w_rr[PW-1], w_rr} - {w_ii[PW-1], w_ii};
        w_im = {w_ri, 1'b0};
        w_nr = etfp_pkg::t_coord'(w_re >>> etfp_pkg::FracBits) + i_cr;
        w_ni = etfp_pkg::t_coord'(w_im >>> etfp_pkg::FracBits) + i_ci;
        w_esc = (w_nr > Lim) || (w_nr < -Lim) || (w_ni > Lim) || (w_ni < -Lim);
        n_tok = i_tok;
        if (i_tok.live && !i_tok.done) begin
            n_tok.zr    = w_nr;
            n_tok.zi    = w_ni;
            n_tok.count = i_tok.count + 1'b1;
            n_tok.done  = w_esc ||
                (i_tok.count + 1'b1 == etfp_pkg::CountW'(etfp_pkg::MaxIter));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.live <= 1'b0;
            r_tok.done <= 1'b0;
        end else begin
            r_tok.live <= n_tok.live;
            r_tok.done <= n_tok.done;
        end
        r_tok.zr    <= n_tok.zr;
        r_tok.zi    <= n_tok.zi;
        r_tok.count <= n_tok.count;
    end

    assign o_tok = r_tok;
endmodule
`default_nettype wire

@@ sv/escape_time_fractal_pixel.sv @@
// a loaded pixel's token laps the ring of two step cells until it escapes
// or reaches the iteration limit; the result is then registered for output
// throughput: one pixel at a time; tready returns the cycle after the
// result transfer
// reset: synchronous active-low i_rst_n clears the state, the configuration
// registers and the cell valid flags
`default_nettype none
module escape_time_fractal_pixel (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [22:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,  // pixel_column[9:0], pixel_row[19:10], zero pad
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata   // out_column, out_row, iteration_count, gray_level
);
    localparam int CW = etfp_pkg::CoordW;
    localparam int Den = etfp_pkg::MaxIter - 2;
    localparam int RecipSh = 21;
    localparam int RecipDen = ((1 << RecipSh) + Den - 1) / Den;

    logic                 r_mode;
    logic signed [22:0]   r_jr, r_ji;
    etfp_pkg::t_state     r_state, n_state;
    etfp_pkg::t_coord     r_cr, r_ci;
    logic [9:0]           r_col, r_row;
    logic [etfp_pkg::CountW-1:0] r_cnt;
    logic [7:0]           r_gray;
    etfp_pkg::t_tok       w_seed, w_t0, w_t1, w_in0;
    etfp_pkg::t_coord     w_x, w_y;
    etfp_pkg::t_coord     w_cr, w_ci, w_cr0, w_ci0;
    logic                 w_load, w_fin;
    logic [15:0]          w_num;
    logic [31:0]          w_prod;
    logic [7:0]           w_q;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_jr   <= '0;
            r_ji   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                etfp_pkg::RegMode: r_mode <= i_cfg_data[0];
                etfp_pkg::RegReal: r_jr   <= i_cfg_data;
                etfp_pkg::RegImag: r_ji   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pixel to Q.20 coordinate: size is a power of two, so index*4/size is a shift
    always_comb begin
        w_x = CW'(signed'({1'b0, s_axis_tdata[9:0], 12'b0})) - (CW'(2) <<< 20);
        w_y = CW'(signed'({1'b0, s_axis_tdata[19:10], 12'b0})) - (CW'(2) <<< 20);
        w_cr = r_mode ? CW'(r_jr) : w_x;
        w_ci = r_mode ? CW'(r_ji) : w_y;
        w_seed = '{live: 1'b1, done: 1'b0, zr: w_x, zi: w_y, count: '0};
    end

    assign s_axis_tready = (r_state == etfp_pkg::ST_IDLE);
    assign w_load = s_axis_tvalid && s_axis_tready;
    assign w_fin  = w_t1.live && w_t1.done;

    // ring of two cells; the token enters at the head on load
    always_comb begin
        w_in0 = w_t1;
        if (w_load) w_in0 = w_seed;
        else if (w_fin || r_state != etfp_pkg::ST_RUN) w_in0.live = 1'b0;
    end

    // head cell takes the new constant in the load cycle
    always_comb begin
        w_cr0 = w_load ? w_cr : r_cr;
        w_ci0 = w_load ? w_ci : r_ci;
    end

    etfp_cell u_c0 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_tok(w_in0),
                    .i_cr(w_cr0), .i_ci(w_ci0), .o_tok(w_t0));
    etfp_cell u_c1 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_tok(w_t0),
                    .i_cr(r_cr), .i_ci(r_ci), .o_tok(w_t1));

    // gray level: 255 minus ceil(255*(k-2)/98), the quotient by reciprocal multiplication
    always_comb begin
        w_num  = 16'(255) * 16'(w_t1.count - 7'd2) + 16'(Den - 1);
        w_prod = 32'(w_num) * 32'(RecipDen);
        w_q    = 8'(w_prod >> RecipSh);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            etfp_pkg::ST_IDLE: if (w_load) n_state = etfp_pkg::ST_RUN;
            etfp_pkg::ST_RUN:  if (w_fin)  n_state = etfp_pkg::ST_OUT;
            etfp_pkg::ST_OUT:  if (m_axis_tready) n_state = etfp_pkg::ST_IDLE;
            default:           n_state = etfp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= etfp_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // pixel payload and result capture
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_col <= s_axis_tdata[9:0];
            r_row <= 10'(etfp_pkg::ImageHeight - 1) - s_axis_tdata[19:10];
            r_cr  <= w_cr;
            r_ci  <= w_ci;
        end
        if (r_state == etfp_pkg::ST_RUN && w_fin) begin
            r_cnt  <= w_t1.count;
            r_gray <= (w_t1.count < 7'd2) ? 8'd0 : 8'd255 - w_q;
        end
    end

    assign m_axis_tvalid = (r_state == etfp_pkg::ST_OUT);
    assign m_axis_tdata  = {5'b0, r_gray, r_cnt, r_row, r_col};

    a_one_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result held");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_cnt != 7'd0)) else $error("zero iteration count");
    a_fin_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == etfp_pkg::ST_RUN))
        else $error("result without run");
endmodule
`default_nettype wire
